// ===== src/int_key_hash_table_core_macros.svh =====
// Assertion macros for the integer-key hash table core.
`ifndef INT_KEY_HASH_TABLE_CORE_MACROS_SVH
`define INT_KEY_HASH_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every rising clock edge outside reset
`define IKHT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ikht assertion failed");
// cond must never be true outside reset
`define IKHT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ikht forbidden condition seen");
`else
`define IKHT_ASSERT(lbl, clk, rst_n, prop)
`define IKHT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== src/ikht_pkg.sv =====
// Types and constants of the integer-key hash table core.
`timescale 1ns / 1ps
`default_nettype none

package ikht_pkg;

  localparam int KeyWidth       = 32;
  localparam int ValueWidth     = 32;
  localparam int SlotWidth      = 10;
  localparam int OpWidth        = 2;
  localparam int DefaultLogSize = 10;
  localparam int ProbeStep      = 13;

  localparam logic [KeyWidth-1:0] EmptyKey = '1;

  typedef enum logic [OpWidth-1:0] {
    OP_REGISTER = 2'd0,
    OP_QUERY    = 2'd1,
    OP_ERASE    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CHECK = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ===== src/int_key_hash_table_core.sv =====
// Integer-key open-addressing hash table with a fixed-stride probe sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "int_key_hash_table_core_macros.svh"

// Integer-key hash table over 2^LOG_SIZE slots held in two single-port memories
// (key and value). A command word is taken when start_i is high and busy_o low;
// exactly one result word follows, shown for one cycle with done_o high, and the
// receiver cannot stall it. After reset the block runs a clearing pass over all
// 2^LOG_SIZE slots (every key set to the empty marker, every value to zero)
// with busy_o high. A command that probes walks its chain in probe steps: each
// step is a memory read (ST_READ) followed by a compare (ST_CHECK) on the
// shared read port; the probe chain length sets how long busy_o stays high, and
// no new word is taken meanwhile. A command on a halted table or with the unused
// opcode is answered in the next cycle without touching the memories. busy_o
// drops in the cycle that carries done_o, so a new word may be started then.
// Home slot: XOR fold of the key in LOG_SIZE-bit chunks; step 13 mod table size.
module int_key_hash_table_core #(
  parameter int LOG_SIZE = ikht_pkg::DefaultLogSize
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  output logic                                 busy_o,
  input  wire         [ikht_pkg::OpWidth-1:0]    opcode_i,
  input  wire         [ikht_pkg::KeyWidth-1:0]   key_i,
  input  wire  signed [ikht_pkg::ValueWidth-1:0] value_i,
  output logic                                 done_o,
  output logic signed [ikht_pkg::ValueWidth-1:0] read_value_o,
  output logic        [ikht_pkg::SlotWidth-1:0]  slot_o,
  output logic                                 added_o,
  output logic                                 half_full_warning_o,
  output logic                                 overflow_o
);

  localparam int KW     = ikht_pkg::KeyWidth;
  localparam int VW     = ikht_pkg::ValueWidth;
  localparam int SW     = ikht_pkg::SlotWidth;
  localparam int Depth  = 1 << LOG_SIZE;
  localparam int Chunks = (KW + LOG_SIZE - 1) / LOG_SIZE;

  localparam logic [LOG_SIZE-1:0] Step      = LOG_SIZE'(ikht_pkg::ProbeStep);
  localparam logic [LOG_SIZE:0]   TableSize = (LOG_SIZE+1)'(Depth);
  localparam logic [LOG_SIZE:0]   HalfSize  = (LOG_SIZE+1)'(Depth / 2);

  // sequencer and bookkeeping
  ikht_pkg::state_e state_q, state_d;
  logic [LOG_SIZE-1:0] addr_q, addr_d;   // probe slot, also clear sweep pointer
  logic [LOG_SIZE-1:0] step_cnt_q, step_cnt_d;
  logic [LOG_SIZE:0]   entry_count_q, entry_count_d;
  logic                halted_q, halted_d;

  // latched command word
  ikht_pkg::op_e   op_q, op_d;
  logic [KW-1:0]   key_q, key_d;
  logic [VW-1:0]   value_q, value_d;

  // result word
  logic                 done_q, done_d;
  logic signed [VW-1:0] rv_q, rv_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic                 added_q, added_d;
  logic                 warn_q, warn_d;
  logic                 ovf_q, ovf_d;

  // memories
  logic [KW-1:0] key_mem [Depth];
  logic [VW-1:0] val_mem [Depth];
  logic [KW-1:0] rd_key_q;
  logic [VW-1:0] rd_val_q;
  logic          key_we, val_we;
  logic [KW-1:0] key_wdata;
  logic [VW-1:0] val_wdata;

  // home slot: XOR of all key chunks (zero chunks drop out)
  logic [LOG_SIZE-1:0] home;
  always_comb begin
    home = '0;
    for (int i = 0; i < Chunks; i++) begin
      home = home ^ LOG_SIZE'(key_i >> (i * LOG_SIZE));
    end
  end

  // probe outcome in the compare cycle
  logic                 slot_empty, key_hit, last_step;
  logic [VW-1:0]        found_val;
  logic [LOG_SIZE:0]    count_inc;
  logic                 new_halt;
  logic                 probe_go;

  assign slot_empty = (rd_key_q == ikht_pkg::EmptyKey);
  assign key_hit    = (rd_key_q == key_q);
  assign last_step  = &step_cnt_q;
  assign found_val  = slot_empty ? '0 : rd_val_q;
  assign count_inc  = entry_count_q + 1'b1;
  assign new_halt   = (count_inc == TableSize);

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    step_cnt_d    = step_cnt_q;
    entry_count_d = entry_count_q;
    halted_d      = halted_q;
    op_d          = op_q;
    key_d         = key_q;
    value_d       = value_q;
    done_d        = 1'b0;
    rv_d          = rv_q;
    slot_d        = slot_q;
    added_d       = added_q;
    warn_d        = warn_q;
    ovf_d         = ovf_q;
    key_we        = 1'b0;
    val_we        = 1'b0;
    key_wdata     = ikht_pkg::EmptyKey;
    val_wdata     = '0;

    unique case (state_q)
      ikht_pkg::ST_CLEAR: begin
        key_we = 1'b1;
        val_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (&addr_q) begin
          state_d = ikht_pkg::ST_IDLE;
        end
      end

      ikht_pkg::ST_IDLE: begin
        if (start_i) begin
          if (halted_q || opcode_i == ikht_pkg::OP_NONE) begin
            // answered at once, table untouched
            done_d  = 1'b1;
            rv_d    = '0;
            slot_d  = '0;
            added_d = 1'b0;
            warn_d  = (entry_count_q > HalfSize);
            ovf_d   = halted_q;
          end else begin
            op_d       = ikht_pkg::op_e'(opcode_i);
            key_d      = key_i;
            value_d    = value_i;
            addr_d     = home;
            step_cnt_d = '0;
            state_d    = ikht_pkg::ST_READ;
          end
        end
      end

      ikht_pkg::ST_READ: begin
        state_d = ikht_pkg::ST_CHECK;
      end

      ikht_pkg::ST_CHECK: begin
        if (!(slot_empty || key_hit || last_step)) begin
          addr_d     = addr_q + Step;
          step_cnt_d = step_cnt_q + 1'b1;
          state_d    = ikht_pkg::ST_READ;
        end else begin
          state_d = ikht_pkg::ST_IDLE;
          done_d  = 1'b1;
          rv_d    = $signed(found_val);
          slot_d  = SW'(addr_q);
          added_d = 1'b0;
          // an empty slot gets its value zeroed, unless a register writes its own value
          val_we    = slot_empty;
          val_wdata = '0;
          case (op_q)
            ikht_pkg::OP_REGISTER: begin
              val_we    = 1'b1;
              val_wdata = value_q;
              if (found_val == '0) begin
                key_we        = 1'b1;
                key_wdata     = key_q;
                entry_count_d = count_inc;
                added_d       = 1'b1;
                if (new_halt) begin
                  // overflow: value stays as probed (zero)
                  halted_d  = 1'b1;
                  val_wdata = '0;
                end
              end
            end
            ikht_pkg::OP_ERASE: begin
              key_we    = 1'b1;
              key_wdata = ikht_pkg::EmptyKey;
            end
            default: ;
          endcase
          warn_d = (entry_count_d > HalfSize);
          ovf_d  = halted_d;
        end
      end

      default: begin
        state_d = ikht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ikht_pkg::ST_CLEAR;
      addr_q        <= '0;
      step_cnt_q    <= '0;
      entry_count_q <= '0;
      halted_q      <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      addr_q        <= addr_d;
      step_cnt_q    <= step_cnt_d;
      entry_count_q <= entry_count_d;
      halted_q      <= halted_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    value_q <= value_d;
    rv_q    <= rv_d;
    slot_q  <= slot_d;
    added_q <= added_d;
    warn_q  <= warn_d;
    ovf_q   <= ovf_d;
  end

  // single-port memories, registered read at the probe pointer
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[addr_q] <= key_wdata;
    end
    rd_key_q <= key_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[addr_q] <= val_wdata;
    end
    rd_val_q <= val_mem[addr_q];
  end

  assign busy_o              = (state_q != ikht_pkg::ST_IDLE);
  assign done_o              = done_q;
  assign read_value_o        = rv_q;
  assign slot_o              = slot_q;
  assign added_o             = added_q;
  assign half_full_warning_o = warn_q;
  assign overflow_o          = ovf_q;

  // word taken that needs a probe
  assign probe_go = start_i && !busy_o && !halted_q && (opcode_i != ikht_pkg::OP_NONE);

  // a result always comes with the sequencer back at rest
  `IKHT_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o)
  // a probing command starts a memory read and gives no result yet
  `IKHT_ASSERT(a_start_probe, clk_i, rst_ni, probe_go |=> (state_q == ikht_pkg::ST_READ && !done_o))
  // halt flag tracks a full count
  `IKHT_ASSERT(a_halt_count, clk_i, rst_ni, halted_q == (entry_count_q == TableSize))
  // count can never pass the table size
  `IKHT_ASSERT_NEVER(a_count_max, clk_i, rst_ni, entry_count_q > TableSize)
  // overflow is only reported once the table is halted
  `IKHT_ASSERT(a_ovf_halt, clk_i, rst_ni, (done_o && overflow_o) |-> halted_q)

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the integer-key hash table core.
`timescale 1ns / 1ps

module tb;
  import ikht_pkg::*;

  localparam int TblLog     = DefaultLogSize;
  localparam int TblSize    = 1 << TblLog;
  localparam int QuietLimit = 20000;  // far above the longest legal silence (clear pass or a full probe chain)
  localparam int RandomCmds = 120;
  localparam int FillCmds   = 1030;   // enough fresh keys to overflow any table state
  localparam int PoolSize   = 48;
  localparam int TailCycles = 16;

  typedef struct packed {
    op_e                   op;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ValueWidth-1:0] read_value;
    logic [SlotWidth-1:0]  slot;
    logic                  added;
    logic                  half_full_warning;
    logic                  overflow;
  } result_t;

  logic                         clk_i    = 1'b0;
  logic                         rst_ni   = 1'b0;
  logic                         start_i  = 1'b0;
  logic        [OpWidth-1:0]    opcode_i = '0;
  logic        [KeyWidth-1:0]   key_i    = '0;
  logic signed [ValueWidth-1:0] value_i  = '0;
  logic                         busy_o;
  logic                         done_o;
  logic signed [ValueWidth-1:0] read_value_o;
  logic        [SlotWidth-1:0]  slot_o;
  logic                         added_o;
  logic                         half_full_warning_o;
  logic                         overflow_o;

  int_key_hash_table_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .opcode_i            (opcode_i),
    .key_i               (key_i),
    .value_i             (value_i),
    .done_o              (done_o),
    .read_value_o        (read_value_o),
    .slot_o              (slot_o),
    .added_o             (added_o),
    .half_full_warning_o (half_full_warning_o),
    .overflow_o          (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the table
  logic [KeyWidth-1:0]   key_shadow   [TblSize];
  logic [ValueWidth-1:0] value_shadow [TblSize];
  int unsigned           entry_total;
  bit                    table_halted;

  cmd_t        cmd_queue[$];
  result_t     expected_words[$];
  int          mismatch_cnt = 0;
  int          results_seen = 0;
  int          total_cmds   = 0;
  int          quiet_cycles = 0;
  logic        word_taken   = 1'b0;
  int          gap_left     = 0;
  int          stretch_left = 0;
  bit          no_idle      = 1'b0;
  logic [KeyWidth-1:0] key_pool [PoolSize];
  logic [KeyWidth-1:0] family_base;

  // XOR fold of the key in TblLog-bit chunks
  function automatic int unsigned home_slot(logic [KeyWidth-1:0] k);
    int unsigned h;
    h = 0;
    while (k != '0) begin
      h = h ^ 32'(k[TblLog-1:0]);
      k = k >> TblLog;
    end
    return h;
  endfunction

  // walk the stride-13 chain; landing on an empty slot clears its value
  function automatic int unsigned probe_slot(logic [KeyWidth-1:0] k);
    int unsigned pos;
    pos = home_slot(k);
    for (int unsigned n = 0; n < TblSize; n++) begin
      if (key_shadow[pos] == EmptyKey) begin
        value_shadow[pos] = '0;
        return pos;
      end
      if (key_shadow[pos] == k) return pos;
      if (n + 1 < TblSize) pos = (pos + ProbeStep) & (TblSize - 1);
    end
    return pos;
  endfunction

  task automatic apply_to_table(input cmd_t c, output result_t r);
    int unsigned pos;
    r = '0;
    if (!table_halted) begin
      case (c.op)
        OP_REGISTER: begin
          pos          = probe_slot(c.key);
          r.read_value = value_shadow[pos];
          r.slot       = SlotWidth'(pos);
          if (r.read_value == '0) begin
            key_shadow[pos] = c.key;
            entry_total++;
            r.added = 1'b1;
            if (entry_total >= TblSize) table_halted = 1'b1;
          end
          if (!table_halted) value_shadow[pos] = c.value;
        end
        OP_QUERY: begin
          pos          = probe_slot(c.key);
          r.read_value = value_shadow[pos];
          r.slot       = SlotWidth'(pos);
        end
        OP_ERASE: begin
          pos             = probe_slot(c.key);
          r.read_value    = value_shadow[pos];
          r.slot          = SlotWidth'(pos);
          key_shadow[pos] = EmptyKey;
        end
        default: ;
      endcase
    end
    r.half_full_warning = (entry_total > (TblSize >> 1));
    r.overflow          = table_halted;
  endtask

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic push_cmd(input op_e op, input logic [KeyWidth-1:0] k,
                          input logic [ValueWidth-1:0] v);
    cmd_t c;
    c.op    = op;
    c.key   = k;
    c.value = v;
    cmd_queue.push_back(c);
  endtask

  // keeps the folded home slot of family_base
  function automatic logic [KeyWidth-1:0] family_key();
    logic [9:0] x;
    x = 10'($urandom);
    return family_base ^ {12'd0, x, x};
  endfunction

  function automatic logic [KeyWidth-1:0] pick_key();
    int unsigned         r;
    logic [KeyWidth-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 85) k = key_pool[$urandom_range(0, PoolSize - 1)];
    else if (r < 95) k = $urandom;
    else begin
      case ($urandom_range(0, 3))
        0:       k = '0;
        1:       k = '1;
        2:       k = 32'hFFFF_FFFE;
        default: k = 32'd1;
      endcase
    end
    return k;
  endfunction

  function automatic logic [ValueWidth-1:0] pick_value();
    int unsigned           r;
    logic [ValueWidth-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 8) v = '0;
    else if (r < 10) v = 32'h7FFF_FFFF;
    else if (r < 12) v = 32'h8000_0000;
    else if (r < 14) v = '1;
    else v = $urandom;
    return v;
  endfunction

  // command driver: holds a word until taken, then idles for the drawn gap
  always @(negedge clk_i) begin : drive_blk
    cmd_t item;
    if (rst_ni && (!start_i || word_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        item = cmd_queue.pop_front();
        opcode_i <= item.op;
        key_i    <= item.key;
        value_i  <= item.value;
        start_i  <= 1'b1;
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(10, 60);
          no_idle      = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        gap_left = no_idle ? 0 : $urandom_range(0, 13);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // result monitor: check the result word first, then predict the newly taken command
  always @(posedge clk_i) begin : watch_blk
    result_t got;
    result_t want;
    result_t fresh;
    cmd_t    taken;
    if (rst_ni) begin
      if (done_o) begin
        got.read_value        = read_value_o;
        got.slot              = slot_o;
        got.added             = added_o;
        got.half_full_warning = half_full_warning_o;
        got.overflow          = overflow_o;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word %0d with no command pending", results_seen));
        end else begin
          want = expected_words.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch($sformatf("word %0d read_value %0d, expected %0d", results_seen,
                                      $signed(got.read_value), $signed(want.read_value)));
          if (got.slot !== want.slot)
            report_mismatch($sformatf("word %0d slot %0d, expected %0d", results_seen,
                                      got.slot, want.slot));
          if (got.added !== want.added)
            report_mismatch($sformatf("word %0d added %b, expected %b", results_seen,
                                      got.added, want.added));
          if (got.half_full_warning !== want.half_full_warning)
            report_mismatch($sformatf("word %0d half_full_warning %b, expected %b",
                                      results_seen, got.half_full_warning,
                                      want.half_full_warning));
          if (got.overflow !== want.overflow)
            report_mismatch($sformatf("word %0d overflow %b, expected %b", results_seen,
                                      got.overflow, want.overflow));
        end
        results_seen++;
      end
      if (start_i && !busy_o) begin
        taken.op    = op_e'(opcode_i);
        taken.key   = key_i;
        taken.value = value_i;
        apply_to_table(taken, fresh);
        expected_words.push_back(fresh);
      end
      word_taken <= start_i && !busy_o;
    end else begin
      word_taken <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stim_blk
    int unsigned r;
    for (int i = 0; i < TblSize; i++) begin
      key_shadow[i]   = EmptyKey;
      value_shadow[i] = '0;
    end
    entry_total  = 0;
    table_halted = 1'b0;

    family_base = $urandom;
    for (int i = 0; i < PoolSize; i++) begin
      case (i % 3)
        0:       key_pool[i] = 32'(1 + ProbeStep * i);  // small keys on the chain from slot 1
        1:       key_pool[i] = family_key();
        default: key_pool[i] = $urandom;
      endcase
    end

    // directed: empty lookup, value extremes, collisions, zero and all-ones keys,
    // erase without tombstone, re-add after zero value, unused opcode
    push_cmd(OP_QUERY,    32'd1,        32'd0);
    push_cmd(OP_REGISTER, 32'd1,        32'h7FFF_FFFF);
    push_cmd(OP_REGISTER, 32'd1,        32'h8000_0000);
    push_cmd(OP_QUERY,    32'd1,        32'd0);
    push_cmd(OP_REGISTER, 32'h0000_1404, 32'hFFFF_FFFF);  // same home slot as key 1
    push_cmd(OP_QUERY,    32'h0000_1404, 32'd0);
    push_cmd(OP_REGISTER, 32'd0,        32'd5);
    push_cmd(OP_REGISTER, 32'hFFFF_FFFF, 32'd9);
    push_cmd(OP_QUERY,    32'hFFFF_FFFF, 32'd0);
    push_cmd(OP_REGISTER, 32'hFFFF_FFFE, 32'h1234_5678);
    push_cmd(OP_ERASE,    32'd1,        32'd0);
    push_cmd(OP_QUERY,    32'h0000_1404, 32'd0);  // chain broken by the erase
    push_cmd(OP_REGISTER, 32'h0000_1404, 32'd0);
    push_cmd(OP_REGISTER, 32'h0000_1404, 32'd3);  // old value zero: added again
    push_cmd(OP_ERASE,    32'hDEAD_BEEF, 32'd0);
    push_cmd(OP_NONE,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(OP_QUERY,    32'd0,        32'd0);
    push_cmd(OP_ERASE,    32'd0,        32'd0);
    push_cmd(OP_REGISTER, 32'd0,        32'd1);
    push_cmd(OP_QUERY,    32'hFFFF_FFFE, 32'hFFFF_FFFF);

    // random mix over a small key pool so chains form and get revisited
    for (int i = 0; i < RandomCmds; i++) begin
      if ($urandom_range(0, 99) < 3)
        key_pool[$urandom_range(0, PoolSize - 1)] =
          ($urandom_range(0, 1) != 0) ? family_key() : 32'($urandom);
      r = $urandom_range(0, 99);
      if (r < 42) push_cmd(OP_REGISTER, pick_key(), pick_value());
      else if (r < 72) push_cmd(OP_QUERY, pick_key(), $urandom);
      else if (r < 90) push_cmd(OP_ERASE, pick_key(), $urandom);
      else if (r < 95) push_cmd(OP_NONE, $urandom, $urandom);
      else push_cmd(op_e'($urandom_range(0, 2)), $urandom, $urandom);
    end

    // fill past half load up to the overflow halt
    for (int i = 0; i < FillCmds; i++) begin
      push_cmd(OP_REGISTER, $urandom, pick_value());
      if ($urandom_range(0, 19) == 0) push_cmd(OP_QUERY, pick_key(), $urandom);
    end

    // halted table: every opcode is ignored
    push_cmd(OP_REGISTER, key_pool[0], 32'd7);
    push_cmd(OP_QUERY,    key_pool[0], 32'd0);
    push_cmd(OP_ERASE,    key_pool[0], 32'd0);
    push_cmd(OP_NONE,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) push_cmd(op_e'($urandom_range(0, 3)), $urandom, $urandom);

    total_cmds = cmd_queue.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < total_cmds) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));

    if (mismatch_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
